/* hw/rtl/csp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the CAN segment packer.
package csp_pkg;

   localparam logic [10:0] PAYLOAD_BASE   = 11'h050;
   localparam logic [10:0] CONTROL_BASE   = 11'h051;
   localparam logic [7:0]  ACK_CHAR       = 8'h41;
   localparam logic [7:0]  TERMINATE_CODE = 8'h01;
   localparam int          CSR_IDX_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_ECU = 2'd0,
      CSR_TIMEOUT    = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_DATA   = 3'd0,
      OP_END    = 3'd1,
      OP_UPDATE = 3'd2,
      OP_RX     = 3'd3,
      OP_TICK   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_ACK     = 2'd1,
      ST_FAIL    = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  data_byte;
      logic [31:0] record_start_address;
      logic [7:0]  image_type;
      logic [10:0] rx_id;
      logic        rx_standard;
      logic        rx_data_frame;
      logic [3:0]  rx_length;
      logic [7:0]  rx_first_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [3:0]  tx_length;
      logic        tx_is_control;
      logic [31:0] tx_address;
      logic [31:0] tx_payload;
      logic [7:0]  tx_control_byte;
      logic [1:0]  status;
   } rsp_type;

endpackage

/* hw/rtl/csp_skid.sv */
`timescale 1ns / 1ps
// Two-entry output buffer: result register plus skid register.
module csp_skid
   import csp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

endmodule

/* hw/rtl/can_segment_packer_with_ack.sv */
`timescale 1ns / 1ps
// Top level of the CAN segment packer with acknowledge handling.
// Takes one request beat per cycle while the skid register is empty and returns
// exactly one response beat for it, in order, via the result register (or the skid
// when stalled). Image bytes are packed into SEGMENT_BYTES-byte payload frames (ID
// 0x50 + 2*ECU, address then data); after each payload or update frame the block
// waits for an 'A' acknowledge on ID 0x51 + 2*ECU, counting tick beats against the
// timeout CSR. A failed wait locks the block, refusing beats with status 3, until
// the next update request. Throughput is one beat per clock unless stalled: all
// decoding and packing is a single level of logic between the request port and the
// result register, and a skid register keeps req_ready independent of rsp_ready.
// CSR writes are to be issued only while no beat is in flight.
module can_segment_packer_with_ack
   import csp_pkg::*;
#(
   parameter int SEGMENT_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);

   localparam int FILL_W = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;

   logic [3:0]        ecu_ff;
   logic [23:0]       timeout_ff;
   logic [7:0]        seg_bytes_ff [SEGMENT_BYTES];
   logic [FILL_W-1:0] fill_ff,    fill_in;
   logic [31:0]       addr_ff,    addr_in;
   logic              latched_ff, latched_in;
   logic              await_ff,   await_in;
   logic [23:0]       ticks_ff,   ticks_in;
   logic              term_ff,    term_in;
   logic              failed_ff,  failed_in;

   logic              accept;
   logic              store_byte;
   logic              last_byte;
   logic              ack_match;
   logic [10:0]       payload_id;
   logic [10:0]       control_id;
   logic [31:0]       eff_addr;
   logic [31:0]       packed_payload;
   rsp_type           rsp_next;

   assign accept     = req_valid && req_ready;
   assign payload_id = PAYLOAD_BASE + {6'd0, ecu_ff, 1'b0};
   assign control_id = CONTROL_BASE + {6'd0, ecu_ff, 1'b0};
   assign last_byte  = (fill_ff == FILL_W'(SEGMENT_BYTES - 1));
   assign eff_addr   = latched_ff ? addr_ff : req_item.record_start_address;
   assign ack_match  = req_item.rx_standard && req_item.rx_data_frame
                       && (req_item.rx_id == control_id)
                       && (req_item.rx_length == 4'd1)
                       && (req_item.rx_first_byte == ACK_CHAR);

   // stored bytes below fill, plus the incoming byte at position fill on a data beat
   always_comb begin
      packed_payload = '0;
      for (int i = 0; i < SEGMENT_BYTES; i++) begin
         if (FILL_W'(i) < fill_ff) begin
            packed_payload[i*8 +: 8] = seg_bytes_ff[i];
         end else if (FILL_W'(i) == fill_ff && req_item.opcode == OP_DATA) begin
            packed_payload[i*8 +: 8] = req_item.data_byte;
         end
      end
   end

   always_comb begin
      rsp_next   = '0;
      fill_in    = fill_ff;
      addr_in    = addr_ff;
      latched_in = latched_ff;
      await_in   = await_ff;
      ticks_in   = ticks_ff;
      term_in    = term_ff;
      failed_in  = failed_ff;
      store_byte = 1'b0;
      if (req_item.opcode <= OP_TICK && failed_ff && req_item.opcode != OP_UPDATE) begin
         rsp_next.status = ST_REFUSED;
      end else begin
         case (req_item.opcode)
            OP_DATA: begin
               if (await_ff) begin
                  rsp_next.status = ST_REFUSED;
               end else begin
                  latched_in = 1'b1;
                  if (last_byte) begin
                     rsp_next.tx_valid   = 1'b1;
                     rsp_next.tx_id      = payload_id;
                     rsp_next.tx_length  = 4'(4 + SEGMENT_BYTES);
                     rsp_next.tx_address = eff_addr;
                     rsp_next.tx_payload = packed_payload;
                     addr_in  = eff_addr + 32'(SEGMENT_BYTES);
                     fill_in  = '0;
                     await_in = 1'b1;
                     ticks_in = timeout_ff;
                  end else begin
                     addr_in    = eff_addr;
                     store_byte = 1'b1;
                     fill_in    = fill_ff + 1'b1;
                  end
               end
            end
            OP_END: begin
               if (await_ff) begin
                  rsp_next.status = ST_REFUSED;
               end else if (fill_ff != '0) begin
                  rsp_next.tx_valid   = 1'b1;
                  rsp_next.tx_id      = payload_id;
                  rsp_next.tx_length  = 4'd4 + 4'(fill_ff);
                  rsp_next.tx_address = addr_ff;
                  rsp_next.tx_payload = packed_payload;
                  addr_in  = addr_ff + 32'(SEGMENT_BYTES);
                  fill_in  = '0;
                  await_in = 1'b1;
                  ticks_in = timeout_ff;
                  term_in  = 1'b1;
               end else begin
                  rsp_next.tx_valid        = 1'b1;
                  rsp_next.tx_id           = control_id;
                  rsp_next.tx_length       = 4'd1;
                  rsp_next.tx_is_control   = 1'b1;
                  rsp_next.tx_control_byte = TERMINATE_CODE;
                  term_in    = 1'b0;
                  latched_in = 1'b0;
                  fill_in    = '0;
               end
            end
            OP_UPDATE: begin
               if (await_ff) begin
                  rsp_next.status = ST_REFUSED;
               end else begin
                  rsp_next.tx_valid        = 1'b1;
                  rsp_next.tx_id           = control_id;
                  rsp_next.tx_length       = 4'd1;
                  rsp_next.tx_is_control   = 1'b1;
                  rsp_next.tx_control_byte = req_item.image_type;
                  failed_in  = 1'b0;
                  fill_in    = '0;
                  latched_in = 1'b0;
                  term_in    = 1'b0;
                  await_in   = 1'b1;
                  ticks_in   = timeout_ff;
               end
            end
            OP_RX: begin
               if (await_ff) begin
                  await_in = 1'b0;
                  ticks_in = '0;
                  if (ack_match) begin
                     rsp_next.status = ST_ACK;
                     if (term_ff) begin
                        rsp_next.tx_valid        = 1'b1;
                        rsp_next.tx_id           = control_id;
                        rsp_next.tx_length       = 4'd1;
                        rsp_next.tx_is_control   = 1'b1;
                        rsp_next.tx_control_byte = TERMINATE_CODE;
                        term_in    = 1'b0;
                        latched_in = 1'b0;
                        fill_in    = '0;
                     end
                  end else begin
                     rsp_next.status = ST_FAIL;
                     term_in   = 1'b0;
                     failed_in = 1'b1;
                  end
               end
            end
            OP_TICK: begin
               if (await_ff) begin
                  if (ticks_ff <= 24'd1) begin
                     rsp_next.status = ST_FAIL;
                     await_in  = 1'b0;
                     ticks_in  = '0;
                     term_in   = 1'b0;
                     failed_in = 1'b1;
                  end else begin
                     ticks_in = ticks_ff - 24'd1;
                  end
               end
            end
            default: begin
               rsp_next = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecu_ff     <= '0;
         timeout_ff <= 24'hFFFFFF;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_ECU: ecu_ff     <= csr_wdata[3:0];
            CSR_TIMEOUT:    timeout_ff <= csr_wdata;
            default:        ecu_ff     <= ecu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         addr_ff    <= '0;
         latched_ff <= 1'b0;
         await_ff   <= 1'b0;
         ticks_ff   <= '0;
         term_ff    <= 1'b0;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         fill_ff    <= fill_in;
         addr_ff    <= addr_in;
         latched_ff <= latched_in;
         await_ff   <= await_in;
         ticks_ff   <= ticks_in;
         term_ff    <= term_in;
         failed_ff  <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SEGMENT_BYTES; i++) begin
         if (accept && store_byte && fill_ff == FILL_W'(i)) begin
            seg_bytes_ff[i] <= req_item.data_byte;
         end
      end
   end

   csp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_ready),
      .in_data   (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_item)
   );

   a_failed_not_waiting: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !await_ff)
      else $error("locked after failure while still awaiting an acknowledge");

   a_term_needs_wait: assert property (@(posedge clock) disable iff (reset)
      term_ff |-> await_ff)
      else $error("terminate pending without an outstanding acknowledge");

   a_timeout_ends_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.opcode == OP_TICK && await_ff && ticks_ff <= 24'd1)
      |=> (!await_ff && failed_ff))
      else $error("expired wait did not fail");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no result waiting");

endmodule

/* verif/can_segment_packer_with_ack_test.sv */
`timescale 1ns / 1ps
// Self-checking CAN segment packer bench: directed and random traffic against a predictor.
module can_segment_packer_with_ack_test;
   import csp_pkg::*;

   localparam int SEG        = 4;
   localparam int QUIET_MAX  = 5000;
   localparam int LONG_HOLD  = 400;
   localparam int PHASE_LEN  = 205;
   localparam int N_PHASES   = 8;

   class packer_model;
      logic [3:0]  ecu;
      logic [23:0] timeout;
      logic [7:0]  seg [SEG];
      int unsigned fill;
      logic [31:0] seg_addr;
      bit          addr_held;
      bit          waiting_ack;
      bit          term_pending;
      bit          locked;
      logic [23:0] ticks_left;
      rsp_type     frames_due [$];
      int          errors;

      function new();
         ecu          = '0;
         timeout      = 24'hFF_FFFF;
         foreach (seg[i]) seg[i] = '0;
         fill         = 0;
         seg_addr     = '0;
         addr_held    = 0;
         waiting_ack  = 0;
         term_pending = 0;
         locked       = 0;
         ticks_left   = '0;
         errors       = 0;
      endfunction

      function logic [10:0] control_id();
         return CONTROL_BASE + {6'd0, ecu, 1'b0};
      endfunction

      function void write_reg(csr_index_type idx, logic [23:0] v);
         case (idx)
            CSR_TARGET_ECU: ecu = v[3:0];
            CSR_TIMEOUT:    timeout = v;
            default: ;
         endcase
      endfunction

      function void arm_wait();
         waiting_ack = 1;
         ticks_left  = timeout;
      endfunction

      function void put_control(inout rsp_type o, input logic [7:0] b);
         o.tx_valid        = 1'b1;
         o.tx_id           = control_id();
         o.tx_length       = 4'd1;
         o.tx_is_control   = 1'b1;
         o.tx_address      = '0;
         o.tx_payload      = '0;
         o.tx_control_byte = b;
      endfunction

      function void put_segment(inout rsp_type o, input int unsigned count);
         logic [31:0] p;
         p = '0;
         for (int i = 0; i < count; i++) p[8*i +: 8] = seg[i];
         o.tx_valid        = 1'b1;
         o.tx_id           = PAYLOAD_BASE + {6'd0, ecu, 1'b0};
         o.tx_length       = 4'(4 + count);
         o.tx_is_control   = 1'b0;
         o.tx_address      = seg_addr;
         o.tx_payload      = p;
         o.tx_control_byte = '0;
         seg_addr += SEG;
         fill = 0;
         arm_wait();
      endfunction

      function void send_terminate(inout rsp_type o);
         put_control(o, TERMINATE_CODE);
         term_pending = 0;
         addr_held    = 0;
         fill         = 0;
      endfunction

      function void fail_wait(inout rsp_type o);
         waiting_ack  = 0;
         ticks_left   = '0;
         term_pending = 0;
         locked       = 1;
         o.status     = ST_FAIL;
      endfunction

      function rsp_type predict(req_type r);
         rsp_type o;
         o = '0;
         if (r.opcode > OP_TICK) return o;
         if (locked && r.opcode != OP_UPDATE) begin
            o.status = ST_REFUSED;
            return o;
         end
         case (r.opcode)
            OP_DATA: begin
               if (waiting_ack) begin
                  o.status = ST_REFUSED;
               end else begin
                  if (!addr_held) begin
                     seg_addr  = r.record_start_address;
                     addr_held = 1;
                  end
                  if (fill < SEG) begin
                     seg[fill] = r.data_byte;
                     fill++;
                  end
                  if (fill >= SEG) put_segment(o, SEG);
               end
            end
            OP_END: begin
               if (waiting_ack) begin
                  o.status = ST_REFUSED;
               end else if (fill > 0) begin
                  put_segment(o, fill);
                  term_pending = 1;
               end else begin
                  send_terminate(o);
               end
            end
            OP_UPDATE: begin
               if (waiting_ack) begin
                  o.status = ST_REFUSED;
               end else begin
                  locked       = 0;
                  fill         = 0;
                  addr_held    = 0;
                  term_pending = 0;
                  put_control(o, r.image_type);
                  arm_wait();
               end
            end
            OP_RX: begin
               if (waiting_ack) begin
                  if (r.rx_standard && r.rx_data_frame && r.rx_id == control_id() &&
                      r.rx_length == 4'd1 && r.rx_first_byte == ACK_CHAR) begin
                     waiting_ack = 0;
                     ticks_left  = '0;
                     if (term_pending) send_terminate(o);
                     o.status = ST_ACK;
                  end else begin
                     fail_wait(o);
                  end
               end
            end
            OP_TICK: begin
               if (waiting_ack) begin
                  if (ticks_left <= 24'd1) fail_wait(o);
                  else ticks_left--;
               end
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         frames_due.push_back(predict(r));
      endfunction

      function void compare_field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $display("%0t: %s expected %h actual %h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (frames_due.size() == 0) begin
            $display("%0t: response %h with none expected", $time, a);
            errors++;
            return;
         end
         e = frames_due.pop_front();
         compare_field("tx_valid", 32'(e.tx_valid), 32'(a.tx_valid));
         compare_field("tx_id", 32'(e.tx_id), 32'(a.tx_id));
         compare_field("tx_length", 32'(e.tx_length), 32'(a.tx_length));
         compare_field("tx_is_control", 32'(e.tx_is_control), 32'(a.tx_is_control));
         compare_field("tx_address", e.tx_address, a.tx_address);
         compare_field("tx_payload", e.tx_payload, a.tx_payload);
         compare_field("tx_control_byte", 32'(e.tx_control_byte), 32'(a.tx_control_byte));
         compare_field("status", 32'(e.status), 32'(a.status));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [23:0]          csr_wdata = '0;

   packer_model model;
   int          send_idle = 0;
   int          rx_stall = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          quiet = 0;

   can_segment_packer_with_ack #(.SEGMENT_BYTES(SEG)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) model.check_response(rsp_item);
   end

   initial begin
      while (quiet < QUIET_MAX) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   function req_type rand_req(opcode_type op);
      req_type r;
      r.opcode               = op;
      r.data_byte            = 8'($urandom_range(255));
      r.record_start_address = $urandom;
      r.image_type           = 8'($urandom_range(255));
      r.rx_id                = 11'($urandom_range(2047));
      r.rx_standard          = 1'($urandom_range(1));
      r.rx_data_frame        = 1'($urandom_range(1));
      r.rx_length            = 4'($urandom_range(8));
      r.rx_first_byte        = 8'($urandom_range(255));
      return r;
   endfunction

   function req_type ack_req();
      req_type r;
      r               = rand_req(OP_RX);
      r.rx_id         = model.control_id();
      r.rx_standard   = 1'b1;
      r.rx_data_frame = 1'b1;
      r.rx_length     = 4'd1;
      r.rx_first_byte = ACK_CHAR;
      return r;
   endfunction

   function req_type bad_ack_req();
      req_type r;
      r = ack_req();
      case ($urandom_range(5))
         0: do r.rx_id = 11'($urandom_range(2047)); while (r.rx_id == model.control_id());
         1: r.rx_standard = 1'b0;
         2: r.rx_data_frame = 1'b0;
         3: do r.rx_length = 4'($urandom_range(8)); while (r.rx_length == 4'd1);
         4: do r.rx_first_byte = 8'($urandom_range(255)); while (r.rx_first_byte == ACK_CHAR);
         default: r = rand_req(OP_RX);
      endcase
      return r;
   endfunction

   function req_type byte_req(logic [7:0] b, logic [31:0] addr);
      req_type r;
      r                      = rand_req(OP_DATA);
      r.data_byte            = b;
      r.record_start_address = addr;
      return r;
   endfunction

   function req_type next_request();
      int p;
      p = $urandom_range(99);
      if (model.locked) begin
         if (p < 70) return rand_req(OP_UPDATE);
         return rand_req(opcode_type'($urandom_range(4)));
      end
      if (model.waiting_ack) begin
         if (p < 70) return ack_req();
         if (p < 82) return rand_req(OP_TICK);
         if (p < 90) return bad_ack_req();
         return rand_req(opcode_type'($urandom_range(2)));
      end
      if (p < 72) return rand_req(OP_DATA);
      if (p < 82) return rand_req(OP_END);
      if (p < 88) return rand_req(OP_UPDATE);
      if (p < 94) return rand_req(OP_RX);
      return rand_req(OP_TICK);
   endfunction

   task automatic push_request(req_type r);
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.frames_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      model.write_reg(idx, v);
      @(posedge clock);
   endtask

   initial begin
      req_type     r;
      logic [3:0]  ecu_tab  [N_PHASES];
      logic [23:0] tmo_tab  [N_PHASES];
      int          idle_tab [N_PHASES];
      int          stall_tab[N_PHASES];
      model = new();
      ecu_tab   = '{4'd15, 4'd7, 4'd0, 4'($urandom_range(15)), 4'd15,
                    4'($urandom_range(15)), 4'd5, 4'($urandom_range(15))};
      tmo_tab   = '{24'd1, 24'hFF_FFFF, 24'd3, 24'($urandom_range(20, 1)), 24'd0,
                    24'd2, 24'($urandom_range(24'hFF_FFFF, 1)), 24'($urandom_range(6, 1))};
      idle_tab  = '{0, 64, 0, 6, 0, 64, 0, 6};
      stall_tab = '{0, 0, 64, 6, 0, 0, 64, 6};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle traffic, busy refusals, wrap of the address, flush, failure lock
      push_request(rand_req(OP_TICK));
      push_request(rand_req(OP_RX));
      push_request(rand_req(OP_END));
      r = rand_req(OP_UPDATE);
      r.image_type = 8'hFF;
      push_request(r);
      push_request(rand_req(OP_DATA));
      push_request(rand_req(OP_END));
      push_request(rand_req(OP_UPDATE));
      push_request(rand_req(OP_TICK));
      push_request(ack_req());
      push_request(byte_req(8'hFF, 32'hFFFF_FFFF));
      push_request(byte_req(8'h00, 32'h0000_0000));
      push_request(byte_req(8'h80, 32'h1234_5678));
      push_request(byte_req(8'h01, 32'h0000_0000));
      push_request(ack_req());
      push_request(byte_req(8'hAA, 32'h0000_0000));
      push_request(rand_req(OP_END));
      push_request(ack_req());
      push_request(byte_req(8'h5A, 32'h0000_0000));
      push_request(rand_req(OP_END));
      r = ack_req();
      r.rx_length = 4'd8;
      push_request(r);
      push_request(rand_req(OP_DATA));
      push_request(rand_req(OP_RX));
      r = rand_req(OP_UPDATE);
      r.image_type = 8'h00;
      push_request(r);
      push_request(ack_req());

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         repeat (4) @(posedge clock);
         write_reg(CSR_TARGET_ECU, {20'd0, ecu_tab[ph]});
         write_reg(CSR_TIMEOUT, tmo_tab[ph]);
         send_idle = idle_tab[ph];
         rx_stall  = stall_tab[ph];
         if (ph == 0) hold_request = 1;
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (ph == 1 && i == PHASE_LEN / 2) drain();
            if ($urandom_range(99) < send_idle) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while ($urandom_range(99) < send_idle) @(posedge clock);
            end
            push_request(next_request());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (model.errors == 0 && model.frames_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/csp_pkg.sv
hw/rtl/csp_skid.sv
hw/rtl/can_segment_packer_with_ack.sv
verif/can_segment_packer_with_ack_test.sv
